FILE: src/qrpm_pkg.sv
// qrpm_pkg: shared types, constants and arithmetic helpers for qr module placement
// alignment center table, state and config codes, mask evaluation
// no dependencies
`timescale 1ns / 1ps

package qrpm_pkg;

  localparam int MAX_VERSION_DEF = 40;
  localparam int TABLE_VERSIONS  = 41;
  localparam int ALIGN_SLOTS     = 7;

  typedef enum logic [1:0] {
    ST_SETTLE,
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic {
    CFG_VERSION = 1'b0,
    CFG_MASK    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       up;
    logic       left;
    logic       done;
  } walk_t;

  localparam logic [2:0] ALIGN_CNT [0:TABLE_VERSIONS-1] = '{
    3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6,
    3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
  };

  localparam logic [7:0] ALIGN_POS [0:TABLE_VERSIONS-1][0:ALIGN_SLOTS-1] = '{
    '{8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd18,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd22,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd34,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd22,  8'd38,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd24,  8'd42,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd46,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd28,  8'd50,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd54,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd32,  8'd58,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd34,  8'd62,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd46,  8'd66,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd48,  8'd70,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd50,  8'd74,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd54,  8'd78,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd56,  8'd82,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd58,  8'd86,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd34,  8'd62,  8'd90,  8'd0,   8'd0,   8'd0},
    '{8'd6, 8'd28,  8'd50,  8'd72,  8'd94,  8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd50,  8'd74,  8'd98,  8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd0,   8'd0},
    '{8'd6, 8'd28,  8'd54,  8'd80,  8'd106, 8'd0,   8'd0},
    '{8'd6, 8'd32,  8'd58,  8'd84,  8'd110, 8'd0,   8'd0},
    '{8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd0,   8'd0},
    '{8'd6, 8'd34,  8'd62,  8'd90,  8'd118, 8'd0,   8'd0},
    '{8'd6, 8'd26,  8'd50,  8'd74,  8'd98,  8'd122, 8'd0},
    '{8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd0},
    '{8'd6, 8'd26,  8'd52,  8'd78,  8'd104, 8'd130, 8'd0},
    '{8'd6, 8'd30,  8'd56,  8'd82,  8'd108, 8'd134, 8'd0},
    '{8'd6, 8'd34,  8'd60,  8'd86,  8'd112, 8'd138, 8'd0},
    '{8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd0},
    '{8'd6, 8'd34,  8'd62,  8'd90,  8'd118, 8'd146, 8'd0},
    '{8'd6, 8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd150},
    '{8'd6, 8'd24,  8'd50,  8'd76,  8'd102, 8'd128, 8'd154},
    '{8'd6, 8'd28,  8'd54,  8'd80,  8'd106, 8'd132, 8'd158},
    '{8'd6, 8'd32,  8'd58,  8'd84,  8'd110, 8'd136, 8'd162},
    '{8'd6, 8'd26,  8'd54,  8'd82,  8'd110, 8'd138, 8'd166},
    '{8'd6, 8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd170}
  };

  // reciprocal multiply, exact for 8-bit inputs
  function automatic logic [7:0] div3(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd171;
    return {1'b0, p[15:9]};
  endfunction

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [9:0] q3;
    logic [9:0] r;
    q3 = {2'd0, div3(v)} * 10'd3;
    r  = {2'd0, v} - q3;
    return r[1:0];
  endfunction

  function automatic logic [1:0] red3(input logic [2:0] v);
    logic [2:0] r;
    r = (v >= 3'd3) ? (v - 3'd3) : v;
    return r[1:0];
  endfunction

  function automatic logic mask_hit(input logic [2:0] pat, input logic [7:0] row,
                                    input logic [7:0] col);
    logic [1:0] rm3;
    logic [1:0] cm3;
    logic [1:0] s3;
    logic [1:0] p3;
    logic [3:0] prod;
    logic       p2;
    logic       sum2;
    logic [7:0] cq;
    logic       h;
    rm3  = mod3(row);
    cm3  = mod3(col);
    s3   = red3({1'b0, rm3} + {1'b0, cm3});
    prod = {2'd0, rm3} * {2'd0, cm3};
    p3   = red3(prod[2:0]);
    p2   = row[0] & col[0];
    sum2 = row[0] ^ col[0];
    cq   = div3(col);
    case (pat)
      3'd0:    h = !sum2;
      3'd1:    h = !row[0];
      3'd2:    h = (cm3 == 2'd0);
      3'd3:    h = (s3 == 2'd0);
      3'd4:    h = !(row[1] ^ cq[0]);
      3'd5:    h = !p2 && (p3 == 2'd0);
      3'd6:    h = !(p2 ^ p3[0]);
      default: h = !(sum2 ^ p3[0]);
    endcase
    return h;
  endfunction

endpackage

FILE: src/qr_module_placement_mask.sv
// the first bit of an item is held in a pending register at accept, then registered to the output;
// one placed bit per cycle while results do not stall, except where the walk skips a
// function-pattern position (the one shared position test); one byte at a time
// reset: version 1, mask 0, walk settles at the bottom-right corner
// before the first item is taken; a version write repeats that settle pass
`timescale 1ns / 1ps

module qr_module_placement_mask
  import qrpm_pkg::*;
#(
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_module_column,
  output logic [7:0] out_module_row,
  output logic       out_module_dark,
  output logic       out_last_of_byte,
  output logic       out_matrix_full,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  state_t     state_r, state_nxt;
  walk_t      walk_r, walk_nxt;
  walk_t      walk_adv;
  logic [5:0] ver_r, ver_nxt;
  logic [7:0] n_m1_r, n_m1_nxt;
  logic [2:0] mask_r, mask_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic [7:0] pend_col_r, pend_col_nxt;
  logic [7:0] pend_row_r, pend_row_nxt;
  logic       pend_dark_r, pend_dark_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_col_r, out_col_nxt;
  logic [7:0] out_row_r, out_row_nxt;
  logic       out_dark_r, out_dark_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_full_r, out_full_nxt;

  logic [7:0] pos_col;
  logic       func_hit;
  logic       pos_free;
  logic       slot_free;
  logic       mask_bit;
  logic       last_bit;
  logic [5:0] ver_clamped;

  function automatic walk_t advance(input walk_t w, input logic [7:0] n_m1);
    walk_t r;
    r = w;
    if (!w.left) begin
      r.left = 1'b1;
    end else begin
      r.left = 1'b0;
      if (w.up && w.row != 8'd0) begin
        r.row = w.row - 8'd1;
      end else if (!w.up && w.row != n_m1) begin
        r.row = w.row + 8'd1;
      end else if (w.col < 8'd2) begin
        r.done = 1'b1;
      end else begin
        r.col = (w.col == 8'd8) ? 8'd5 : (w.col - 8'd2);
        r.up  = !w.up;
      end
    end
    return r;
  endfunction

  assign pos_col = walk_r.col - {7'd0, walk_r.left};

  qrpm_func_unit u_func (
    .ver      (ver_r),
    .n_m1     (n_m1_r),
    .pos_x    (pos_col),
    .pos_y    (walk_r.row),
    .func_hit (func_hit)
  );

  assign pos_free  = walk_r.done || !func_hit;
  assign slot_free = !out_valid_r || !out_stall;
  assign walk_adv  = advance(walk_r, n_m1_r);
  assign mask_bit  = mask_hit(mask_r, walk_r.row, pos_col);
  assign last_bit  = (rem_r == 3'd0) || walk_r.done;

  assign in_stall          = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_module_column = out_col_r;
  assign out_module_row    = out_row_r;
  assign out_module_dark   = out_dark_r;
  assign out_last_of_byte  = out_last_r;
  assign out_matrix_full   = out_full_r;

  always_comb begin
    ver_clamped = cfg_data;
    if (cfg_data == 6'd0) begin
      ver_clamped = 6'd1;
    end
    if (cfg_data > 6'(MAX_VERSION)) begin
      ver_clamped = 6'(MAX_VERSION);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    ver_nxt       = ver_r;
    n_m1_nxt      = n_m1_r;
    mask_nxt      = mask_r;
    byte_nxt      = byte_r;
    rem_nxt       = rem_r;
    pend_col_nxt  = pend_col_r;
    pend_row_nxt  = pend_row_r;
    pend_dark_nxt = pend_dark_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_dark_nxt  = out_dark_r;
    out_last_nxt  = out_last_r;
    out_full_nxt  = out_full_r;

    case (state_r)
      ST_SETTLE: begin
        if (pos_free) begin
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_adv;
        end
      end
      ST_IDLE: begin
        if (in_valid && !walk_r.done) begin
          byte_nxt      = in_data_byte;
          rem_nxt       = 3'd7;
          pend_col_nxt  = pos_col;
          pend_row_nxt  = walk_r.row;
          pend_dark_nxt = in_data_byte[7] ^ mask_bit;
          walk_nxt      = walk_adv;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!pos_free) begin
          walk_nxt = walk_adv;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = pend_col_r;
          out_row_nxt   = pend_row_r;
          out_dark_nxt  = pend_dark_r;
          out_last_nxt  = last_bit;
          out_full_nxt  = walk_r.done;
          if (last_bit) begin
            state_nxt = ST_IDLE;
          end else begin
            pend_col_nxt  = pos_col;
            pend_row_nxt  = walk_r.row;
            pend_dark_nxt = byte_r[rem_r - 3'd1] ^ mask_bit;
            rem_nxt       = rem_r - 3'd1;
            walk_nxt      = walk_adv;
          end
        end
      end
      default: begin
        state_nxt = ST_SETTLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VERSION: begin
          ver_nxt       = ver_clamped;
          n_m1_nxt      = 8'd16 + {ver_clamped, 2'b00};
          walk_nxt.col  = 8'd16 + {ver_clamped, 2'b00};
          walk_nxt.row  = 8'd16 + {ver_clamped, 2'b00};
          walk_nxt.up   = 1'b1;
          walk_nxt.left = 1'b0;
          walk_nxt.done = 1'b0;
          state_nxt     = ST_SETTLE;
        end
        CFG_MASK: begin
          mask_nxt = cfg_data[2:0];
        end
        default: begin
          mask_nxt = mask_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SETTLE;
      walk_r      <= '{col: 8'd20, row: 8'd20, up: 1'b1, left: 1'b0, done: 1'b0};
      ver_r       <= 6'd1;
      n_m1_r      <= 8'd20;
      mask_r      <= 3'd0;
      rem_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      ver_r       <= ver_nxt;
      n_m1_r      <= n_m1_nxt;
      mask_r      <= mask_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_dark_r <= pend_dark_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_dark_r  <= out_dark_nxt;
    out_last_r  <= out_last_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule

FILE: src/qrpm_func_unit.sv
// qrpm_func_unit: tells whether one matrix position lies on a function pattern
// finders, separators, format, timing, alignment and version areas
// depends on qrpm_pkg
`timescale 1ns / 1ps

module qrpm_func_unit
  import qrpm_pkg::*;
(
  input  logic [5:0] ver,
  input  logic [7:0] n_m1,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  output logic       func_hit
);

  logic [2:0]             cnt;
  logic [ALIGN_SLOTS-1:0] near_x;
  logic [ALIGN_SLOTS-1:0] near_y;
  logic                   align_hit;
  logic                   finder_hit;
  logic                   version_hit;
  logic [8:0]             x9;
  logic [8:0]             y9;
  logic [8:0]             far8;
  logic [8:0]             far11;

  assign x9    = {1'b0, pos_x};
  assign y9    = {1'b0, pos_y};
  assign far8  = {1'b0, n_m1} - 9'd8;
  assign far11 = {1'b0, n_m1} - 9'd11;
  assign cnt   = ALIGN_CNT[ver];

  always_comb begin
    near_x = '0;
    near_y = '0;
    for (int i = 0; i < ALIGN_SLOTS; i++) begin
      if (3'(i) < cnt) begin
        near_x[i] = (x9 + 9'd2 >= {1'b0, ALIGN_POS[ver][i]}) &&
                    (x9 <= {1'b0, ALIGN_POS[ver][i]} + 9'd2);
        near_y[i] = (y9 + 9'd2 >= {1'b0, ALIGN_POS[ver][i]}) &&
                    (y9 <= {1'b0, ALIGN_POS[ver][i]} + 9'd2);
      end
    end
  end

  always_comb begin
    align_hit = 1'b0;
    for (int i = 0; i < ALIGN_SLOTS; i++) begin
      for (int k = 0; k < ALIGN_SLOTS; k++) begin
        if (near_x[i] && near_y[k] &&
            !((i == 0 && k == 0) ||
              (i == 0 && 3'(k) == cnt - 3'd1) ||
              (3'(i) == cnt - 3'd1 && k == 0))) begin
          align_hit = 1'b1;
        end
      end
    end
  end

  assign finder_hit = (pos_x < 8'd9 && (pos_y < 8'd9 || y9 > far8)) ||
                      (x9 > far8 && pos_y < 8'd9);

  assign version_hit = (ver >= 6'd7) &&
                       ((pos_x < 8'd6 && y9 > far11) || (pos_y < 8'd6 && x9 > far11));

  assign func_hit = finder_hit || align_hit || version_hit ||
                    pos_x == 8'd6 || pos_y == 8'd6;

endmodule

FILE: src/qrpm_checker.sv
// qrpm_sva: port-level assertions for qr_module_placement_mask
// attached to the top level by the bind at the end of this file
// depends on the top-level port list only
`timescale 1ns / 1ps

module qrpm_sva (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_module_column,
  input logic [7:0] out_module_row,
  input logic       out_module_dark,
  input logic       out_last_of_byte,
  input logic       out_matrix_full,
  input logic       cfg_ready
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_module_column) &&
      $stable(out_module_row) && $stable(out_module_dark) && $stable(out_last_of_byte) &&
      $stable(out_matrix_full))
    else $error("stalled result item changed");

  // a full matrix always closes the byte
  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matrix_full |-> out_last_of_byte)
    else $error("matrix full without last_of_byte");

  // handshake outputs are always known out of reset
  a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_stall, out_valid, cfg_ready}))
    else $error("unknown handshake output");

  // a valid result item carries known fields
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_module_column, out_module_row, out_module_dark,
                               out_last_of_byte, out_matrix_full}))
    else $error("unknown field in result item");

  // placed modules stay inside the largest symbol
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_module_column <= 8'd176 && out_module_row <= 8'd176)
    else $error("module position outside the symbol");

endmodule

bind qr_module_placement_mask qrpm_sva u_qrpm_sva (.*);

FILE: tb/qrpm_checker.sv
// qrpm_checker: watches the config, input and result channels of qr_module_placement_mask,
// predicts every placed module from its own walk of the symbol and compares results in order
// depends on qrpm_pkg for the config index codes and the version limit
`timescale 1ns / 1ps

module qrpm_checker
  import qrpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_module_column,
  input  logic [7:0] out_module_row,
  input  logic       out_module_dark,
  input  logic       out_last_of_byte,
  input  logic       out_matrix_full,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  output int         mismatch_count,
  output int         modules_pending
);

  typedef enum bit [2:0] {
    MASK_CHECKER,
    MASK_ROWS,
    MASK_COLS,
    MASK_DIAG,
    MASK_BLOCKS,
    MASK_PRODUCT,
    MASK_PRODUCT_PARITY,
    MASK_MIXED
  } mask_formula_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       dark;
    logic       last;
    logic       full;
  } placed_module_t;

  placed_module_t expected_modules[$];
  placed_module_t got;
  placed_module_t want;
  logic [5:0]     version_reg;
  logic [2:0]     mask_reg;
  int             walk_col;
  int             walk_row;
  bit             walk_up;
  bit             on_left;
  bit             matrix_done;

  function automatic int version_used();
    if (version_reg < 6'd1) return 1;
    if (int'(version_reg) > MAX_VERSION_DEF) return MAX_VERSION_DEF;
    return int'(version_reg);
  endfunction

  function automatic int centre_count(int v);
    return (v < 2) ? 0 : v / 7 + 2;
  endfunction

  // alignment centres: 6 first, the rest evenly spaced back from size-7
  function automatic int centre_at(int v, int i);
    int cnt;
    int step;
    cnt  = centre_count(v);
    step = (v == 32) ? 26 : ((4 * v + 2 * cnt + 1) / (2 * cnt - 2)) * 2;
    return (i == 0) ? 6 : 17 + 4 * v - 7 - (cnt - 1 - i) * step;
  endfunction

  function automatic bit close_to(int a, int c);
    return (a >= c - 2) && (a <= c + 2);
  endfunction

  function automatic bit reserved_at(int x, int y);
    int v;
    int n;
    int cnt;
    int i;
    int k;
    v   = version_used();
    n   = 17 + 4 * v;
    cnt = centre_count(v);
    if (x < 9 && (y < 9 || y > n - 9)) return 1'b1;
    if (x > n - 9 && y < 9) return 1'b1;
    for (i = 0; i < cnt; i++) begin
      for (k = 0; k < cnt; k++) begin
        // no alignment pattern where it would sit on a finder
        if (!((i == 0 && k == 0) || (i == 0 && k == cnt - 1) || (i == cnt - 1 && k == 0)) &&
            close_to(x, centre_at(v, i)) && close_to(y, centre_at(v, k)))
          return 1'b1;
      end
    end
    if (x == 6 || y == 6) return 1'b1;
    if (v >= 7 && ((x < 6 && y > n - 12) || (y < 6 && x > n - 12))) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit mask_flips(int r, int c);
    int p;
    p = r * c;
    case (mask_formula_t'(mask_reg))
      MASK_CHECKER:        return (r + c) % 2 == 0;
      MASK_ROWS:           return r % 2 == 0;
      MASK_COLS:           return c % 3 == 0;
      MASK_DIAG:           return (r + c) % 3 == 0;
      MASK_BLOCKS:         return (r / 2 + c / 3) % 2 == 0;
      MASK_PRODUCT:        return (p % 2 + p % 3) == 0;
      MASK_PRODUCT_PARITY: return ((p % 2 + p % 3) % 2) == 0;
      default:             return (((r + c) % 2 + p % 3) % 2) == 0;
    endcase
  endfunction

  function automatic void step_walk();
    int n;
    n = 17 + 4 * version_used();
    if (!on_left) begin
      on_left = 1'b1;
      return;
    end
    on_left = 1'b0;
    if (walk_up && walk_row > 0) begin
      walk_row--;
      return;
    end
    if (!walk_up && walk_row < n - 1) begin
      walk_row++;
      return;
    end
    if (walk_col < 2) begin
      matrix_done = 1'b1;
      return;
    end
    walk_col -= 2;
    if (walk_col == 6) walk_col = 5;
    walk_up = !walk_up;
  endfunction

  function automatic void settle_walk();
    while (!matrix_done && reserved_at(walk_col - on_left, walk_row)) step_walk();
  endfunction

  function automatic void restart_walk();
    walk_col    = 16 + 4 * version_used();
    walk_row    = walk_col;
    walk_up     = 1'b1;
    on_left     = 1'b0;
    matrix_done = 1'b0;
    settle_walk();
  endfunction

  function automatic void place_byte(logic [7:0] b);
    placed_module_t run[8];
    int bit_i;
    int placed;
    placed = 0;
    for (bit_i = 7; bit_i >= 0 && !matrix_done; bit_i--) begin
      run[placed].col  = 8'(walk_col - on_left);
      run[placed].row  = 8'(walk_row);
      run[placed].dark = b[bit_i] ^ mask_flips(walk_row, walk_col - on_left);
      run[placed].last = 1'b0;
      step_walk();
      settle_walk();
      run[placed].full = matrix_done;
      placed++;
    end
    if (placed > 0) run[placed - 1].last = 1'b1;
    for (bit_i = 0; bit_i < placed; bit_i++) expected_modules.push_back(run[bit_i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      version_reg = 6'd1;
      mask_reg    = 3'd0;
      restart_walk();
      expected_modules.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_VERSION) begin
          version_reg = cfg_data;
          restart_walk();
        end else begin
          mask_reg = cfg_data[2:0];
        end
      end
      if (in_valid && !in_stall) place_byte(in_data_byte);
      if (out_valid && !out_stall) begin
        got = {out_module_column, out_module_row, out_module_dark, out_last_of_byte,
               out_matrix_full};
        if (expected_modules.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: col %0d row %0d dark %0b last %0b full %0b",
                     got.col, got.row, got.dark, got.last, got.full);
        end else begin
          want = expected_modules.pop_front();
          if (got.col !== want.col || got.row !== want.row || got.dark !== want.dark ||
              got.last !== want.last || got.full !== want.full) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp col %0d row %0d dark %0b last %0b full %0b, %s",
                       want.col, want.row, want.dark, want.last, want.full,
                       $sformatf("got col %0d row %0d dark %0b last %0b full %0b",
                                 got.col, got.row, got.dark, got.last, got.full));
          end
        end
      end
    end
    modules_pending = expected_modules.size();
  end

endmodule

FILE: tb/testbench.sv
// testbench: clock, reset, config writes and codeword stimulus for qr_module_placement_mask
// random idling on both channels; verdict from the failure count of qrpm_checker
// depends on qrpm_pkg, qr_module_placement_mask and qrpm_checker
`timescale 1ns / 1ps

module testbench;
  import qrpm_pkg::*;

  localparam int SETTLE_WAIT = 200;
  localparam int HOLD_CYCLES = 300;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte      = 8'd0;
  logic       out_valid;
  logic       out_stall         = 1'b0;
  logic [7:0] out_module_column;
  logic [7:0] out_module_row;
  logic       out_module_dark;
  logic       out_last_of_byte;
  logic       out_matrix_full;
  logic       cfg_valid         = 1'b0;
  logic       cfg_ready;
  logic       cfg_index         = CFG_VERSION;
  logic [5:0] cfg_data          = 6'd0;
  logic       rx_hold_go        = 1'b0;
  bit         no_gap            = 1'b0;
  int         mismatch_count;
  int         modules_pending;

  qr_module_placement_mask DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_module_column (out_module_column),
    .out_module_row    (out_module_row),
    .out_module_dark   (out_module_dark),
    .out_last_of_byte  (out_last_of_byte),
    .out_matrix_full   (out_matrix_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  qrpm_checker CHK (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_module_column (out_module_column),
    .out_module_row    (out_module_row),
    .out_module_dark   (out_module_dark),
    .out_last_of_byte  (out_last_of_byte),
    .out_matrix_full   (out_matrix_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .modules_pending   (modules_pending)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // result side: per-item stall, stretches without stalls, one long hold-off
  initial begin : result_sink
    int  wait_left;
    int  hold_left;
    int  taken;
    bit  hold_used;
    bit  no_wait;
    wait_left = 0;
    hold_left = 0;
    taken     = 0;
    hold_used = 1'b0;
    no_wait   = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if (taken % 37 == 0) no_wait = !no_wait;
        wait_left = no_wait ? 0 : $urandom_range(0, 18);
      end
      if (rx_hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 11) == 0) no_gap = !no_gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(8'($urandom));
  endtask

  // wait until every placed module has come back, then let the walk settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (modules_pending != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mask first, since a version write restarts the walk
  task automatic set_symbol(input logic [5:0] ver, input logic [2:0] mask);
    write_reg(CFG_MASK, {3'($urandom), mask});
    write_reg(CFG_VERSION, ver);
  endtask

  initial begin : stimulus
    int m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: version 1, mask 0
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    for (m = 0; m < 8; m++) begin
      drain();
      write_reg(CFG_MASK, {3'($urandom), 3'(m)});
      send_random(1);
    end
    // version 0 reads as 1, 63 as the largest version
    drain();
    write_reg(CFG_VERSION, 6'd0);
    send_random(1);
    drain();
    write_reg(CFG_VERSION, 6'd63);
    send_random(1);
    drain();
    write_reg(CFG_VERSION, 6'd40);
    send_random(1);

    // version 2 ends inside a byte, then an item past the full matrix;
    // sink holds off while items keep coming
    drain();
    set_symbol(6'd2, 3'($urandom));
    rx_hold_go <= 1'b1;
    send_random(20);
    drain();
    write_reg(CFG_MASK, 6'($urandom));
    send_random(26);

    // version 7 far enough to pass the version information block
    drain();
    set_symbol(6'd7, 3'($urandom));
    send_random(21);
    drain();
    send_random(21);

    repeat (3) begin
      drain();
      set_symbol(6'($urandom), 3'($urandom));
      send_random(3);
    end

    drain();
    if (mismatch_count == 0 && modules_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
